// ===== src/qirv_pkg.sv =====
// ----------------------------------------------------------------------------
// qirv_pkg: shared types and constants for the queue index record validator
// Record layout, check codes, register indexes and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package qirv_pkg;

    localparam int REC_LEN  = 40;  // bytes in one index record
    localparam int CRC_LEN  = 36;  // bytes covered by the CRC
    localparam int POS_SAT  = 41;  // byte position saturates here
    localparam int POS_W    = 6;

    localparam logic [15:0] HDR_SIZE = 16'd40;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Verdict codes
    localparam int FAIL_W = 4;
    localparam logic [FAIL_W-1:0] FAIL_OK        = 4'd0;
    localparam logic [FAIL_W-1:0] FAIL_LENGTH    = 4'd1;
    localparam logic [FAIL_W-1:0] FAIL_MAGIC     = 4'd2;
    localparam logic [FAIL_W-1:0] FAIL_VERSION   = 4'd3;
    localparam logic [FAIL_W-1:0] FAIL_HDR_SIZE  = 4'd4;
    localparam logic [FAIL_W-1:0] FAIL_CRC       = 4'd5;
    localparam logic [FAIL_W-1:0] FAIL_ZERO_SIZE = 4'd6;
    localparam logic [FAIL_W-1:0] FAIL_OVER_CAP  = 4'd7;
    localparam logic [FAIL_W-1:0] FAIL_TAIL_HEAD = 4'd8;
    localparam logic [FAIL_W-1:0] FAIL_COUNT     = 4'd9;
    localparam logic [FAIL_W-1:0] FAIL_GEOMETRY  = 4'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_GEOM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 3'd5;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic        check_geom;
        logic [31:0] capacity;
        logic [31:0] record_size;
        logic [31:0] reserved;
    } cfg_t;

    // Captured record, handed from front to back
    typedef struct packed {
        logic        len_ok;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] hdr_size;
        logic [31:0] stored_crc;
        logic [31:0] calc_crc;
        logic [31:0] capacity;
        logic [31:0] record_size;
        logic [31:0] reserved;
        logic [31:0] head;
        logic [31:0] tail;
        logic [31:0] count;
        logic [31:0] generation;
    } summary_t;

    typedef struct packed {
        logic              valid_res;
        logic [FAIL_W-1:0] fail_code;
        logic [31:0]       head_index;
        logic [31:0]       tail_index;
        logic [31:0]       entry_count;
        logic [31:0]       generation_number;
    } verdict_t;

    // One byte of reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== src/qirv_fifo.sv =====
// ----------------------------------------------------------------------------
// qirv_fifo: small register queue
// First-in first-out buffer with full/empty flags; push and pop can share a cycle when it is neither full nor empty.
// ----------------------------------------------------------------------------
module qirv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/qirv_front.sv =====
// ----------------------------------------------------------------------------
// qirv_front: byte intake for the index record validator
// Counts bytes, runs the CRC-32 over the covered span and captures the record;
// on the last byte it hands a summary of the record to the summary queue for the back end.
// ----------------------------------------------------------------------------
module qirv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_take,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                sum_push,
    output qirv_pkg::summary_t  sum_data
);

    import qirv_pkg::*;

    localparam int STORE_N = REC_LEN - 1;  // final byte comes straight from the input

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       rec_reg [STORE_N];

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (in_take)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                crc_next = CRC_INIT;
            end
            else
            begin
                if (pos_reg < POS_W'(POS_SAT))
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (pos_reg < POS_W'(CRC_LEN))
                begin
                    crc_next = crc_byte(crc_reg, data_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    for (genvar i = 0; i < STORE_N; i++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (in_take && pos_reg == POS_W'(i))
            begin
                rec_reg[i] <= data_byte;
            end
        end
    end

    // A good record ends at position REC_LEN-1, past the CRC span, so crc_reg is final
    assign sum_push = in_take && last_byte;

    always_comb
    begin
        sum_data.len_ok      = (pos_reg == POS_W'(REC_LEN - 1));
        sum_data.magic       = {rec_reg[3], rec_reg[2], rec_reg[1], rec_reg[0]};
        sum_data.version     = {rec_reg[5], rec_reg[4]};
        sum_data.hdr_size    = {rec_reg[7], rec_reg[6]};
        sum_data.capacity    = {rec_reg[11], rec_reg[10], rec_reg[9], rec_reg[8]};
        sum_data.record_size = {rec_reg[15], rec_reg[14], rec_reg[13], rec_reg[12]};
        sum_data.reserved    = {rec_reg[19], rec_reg[18], rec_reg[17], rec_reg[16]};
        sum_data.head        = {rec_reg[23], rec_reg[22], rec_reg[21], rec_reg[20]};
        sum_data.tail        = {rec_reg[27], rec_reg[26], rec_reg[25], rec_reg[24]};
        sum_data.count       = {rec_reg[31], rec_reg[30], rec_reg[29], rec_reg[28]};
        sum_data.generation  = {rec_reg[35], rec_reg[34], rec_reg[33], rec_reg[32]};
        sum_data.stored_crc  = {data_byte, rec_reg[38], rec_reg[37], rec_reg[36]};
        sum_data.calc_crc    = ~crc_reg;
    end

endmodule

// ===== src/qirv_back.sv =====
// ----------------------------------------------------------------------------
// qirv_back: verdict stage for the index record validator
// Takes one captured record, runs the ordered checks and forms the result.
// ----------------------------------------------------------------------------
module qirv_back (
    input  qirv_pkg::summary_t sum,
    input  qirv_pkg::cfg_t     cfg,
    output qirv_pkg::verdict_t verdict
);

    import qirv_pkg::*;

    logic [31:0]       span;
    logic [FAIL_W-1:0] code;

    assign span = sum.tail - sum.head;

    // First failing check wins
    always_comb
    begin
        if (!sum.len_ok)
            code = FAIL_LENGTH;
        else if (sum.magic != cfg.magic)
            code = FAIL_MAGIC;
        else if (sum.version != cfg.version)
            code = FAIL_VERSION;
        else if (sum.hdr_size != HDR_SIZE)
            code = FAIL_HDR_SIZE;
        else if (sum.stored_crc != sum.calc_crc)
            code = FAIL_CRC;
        else if (sum.capacity == '0 || sum.record_size == '0 || sum.reserved == '0)
            code = FAIL_ZERO_SIZE;
        else if (sum.count > sum.capacity)
            code = FAIL_OVER_CAP;
        else if (sum.tail < sum.head)
            code = FAIL_TAIL_HEAD;
        else if (sum.count != span)
            code = FAIL_COUNT;
        else if (cfg.check_geom && (sum.capacity != cfg.capacity ||
                                    sum.record_size != cfg.record_size ||
                                    sum.reserved != cfg.reserved))
            code = FAIL_GEOMETRY;
        else
            code = FAIL_OK;
    end

    always_comb
    begin
        verdict.valid_res         = (code == FAIL_OK);
        verdict.fail_code         = code;
        // a record of the wrong length reports zero fields
        verdict.head_index        = sum.len_ok ? sum.head : '0;
        verdict.tail_index        = sum.len_ok ? sum.tail : '0;
        verdict.entry_count       = sum.len_ok ? sum.count : '0;
        verdict.generation_number = sum.len_ok ? sum.generation : '0;
    end

endmodule

// ===== src/queue_index_record_validator_unit.sv =====
// ----------------------------------------------------------------------------
// queue_index_record_validator_unit: persisted queue index record checker
// Streams a 40-byte index record one byte at a time, checks it and reports a
// single verdict with the head, tail, count and generation fields.
// ----------------------------------------------------------------------------
// Push one record byte per clock, last_byte high on the final one; the block
// takes a byte every cycle while full is low. Each record yields one verdict on
// the result queue, held first as a summary in the summary queue and then as a
// verdict in the result queue once its last byte is accepted. The front end feeds a
// MID_DEPTH-entry summary queue; the back end checks the head of that queue
// and writes the verdict into an OUT_DEPTH-entry result queue, so a stalled
// reader blocks input only once both queues fill. cfg_ready is always high;
// write registers only while no record is in flight.
module queue_index_record_validator_unit #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic                           valid_res,
    output logic [qirv_pkg::FAIL_W-1:0]    fail_code,
    output logic [31:0]                    head_index,
    output logic [31:0]                    tail_index,
    output logic [31:0]                    entry_count,
    output logic [31:0]                    generation_number,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qirv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    import qirv_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    summary_t sum_in, sum_out;
    verdict_t verdict_in, verdict_out;
    logic     in_take, sum_push, mid_full, mid_empty, out_full, move;

    assign cfg_ready = 1'b1;
    assign in_take   = push && !full;
    assign full      = mid_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC:       cfg_next.magic       = cfg_data;
                CFG_VERSION:     cfg_next.version     = cfg_data[15:0];
                CFG_CHECK_GEOM:  cfg_next.check_geom  = cfg_data[0];
                CFG_CAPACITY:    cfg_next.capacity    = cfg_data;
                CFG_RECORD_SIZE: cfg_next.record_size = cfg_data;
                CFG_RESERVED:    cfg_next.reserved    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= '0;
            cfg_reg.version     <= 16'd1;
            cfg_reg.check_geom  <= 1'b0;
            cfg_reg.capacity    <= '0;
            cfg_reg.record_size <= '0;
            cfg_reg.reserved    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    qirv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sum_push  (sum_push),
        .sum_data  (sum_in)
    );

    qirv_fifo #(
        .WIDTH ($bits(summary_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .push_data (sum_in),
        .full      (mid_full),
        .pop       (move),
        .pop_data  (sum_out),
        .empty     (mid_empty)
    );

    // advance a summary whenever the result queue has room
    assign move = !mid_empty && !out_full;

    qirv_back u_back (
        .sum     (sum_out),
        .cfg     (cfg_reg),
        .verdict (verdict_in)
    );

    qirv_fifo #(
        .WIDTH ($bits(verdict_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (move),
        .push_data (verdict_in),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (verdict_out),
        .empty     (empty)
    );

    assign valid_res         = verdict_out.valid_res;
    assign fail_code         = verdict_out.fail_code;
    assign head_index        = verdict_out.head_index;
    assign tail_index        = verdict_out.tail_index;
    assign entry_count       = verdict_out.entry_count;
    assign generation_number = verdict_out.generation_number;

endmodule

// ===== src/qirv_checker.sv =====
// ----------------------------------------------------------------------------
// qirv_checker: port-level checks for the index record validator
// Watches the result queue and verdict encoding; bound to the top level.
// ----------------------------------------------------------------------------
module qirv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic                           valid_res,
    input logic [qirv_pkg::FAIL_W-1:0]    fail_code,
    input logic [31:0]                    head_index,
    input logic [31:0]                    tail_index,
    input logic [31:0]                    entry_count,
    input logic [31:0]                    generation_number
);

    import qirv_pkg::*;

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (valid_res == (fail_code == FAIL_OK)))
        else $error("valid_res disagrees with fail_code");

    a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (fail_code <= FAIL_GEOMETRY))
        else $error("fail_code out of range");

    a_length_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && fail_code == FAIL_LENGTH) |->
            (head_index == '0 && tail_index == '0 &&
             entry_count == '0 && generation_number == '0))
        else $error("length failure carries nonzero fields");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(fail_code) && $stable(head_index) &&
                              $stable(generation_number)))
        else $error("waiting result changed before pop");

endmodule

bind queue_index_record_validator_unit qirv_checker u_qirv_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: queue index record validator testbench
// Streams whole index records, broken records and raw noise into the block
// through its push/full queue and checks every verdict on the pop/empty side
// against an in-bench model of the record checks. Covers the reset register
// values, both extremes and random settings, random sender gaps, receiver
// stalls, one long receiver hold that backs up the input and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qirv_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int DRAIN_LIMIT    = 5_000;
    localparam int SETTLE         = 8;
    localparam int LONG_HOLD      = 600;
    localparam int MAX_REPORTS    = 30;
    localparam int RAND_PHASES    = 2;
    localparam int RECS_PER_PHASE = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = CFG_RESERVED + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = 3'd7;

    localparam int RAW_ZERO   = 0;
    localparam int RAW_ONES   = 1;
    localparam int RAW_RANDOM = 2;

    typedef struct {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] hdr;
        logic [31:0] cap;
        logic [31:0] rsz;
        logic [31:0] rsv;
        logic [31:0] head;
        logic [31:0] tail;
        logic [31:0] cnt;
        logic [31:0] gen;
    } idx_rec_t;

    class record_verdict_board;
        cfg_t        regs;
        logic [7:0]  image [REC_LEN];
        int          pos;
        logic [31:0] crc_acc;
        verdict_t    expected_verdicts[$];
        int          mismatches;
        int          verdicts_checked;
        bit [15:0]   codes_seen;

        function new();
            regs             = '0;
            regs.version     = 16'd1;
            pos              = 0;
            crc_acc          = CRC_INIT;
            mismatches       = 0;
            verdicts_checked = 0;
            codes_seen       = '0;
        endfunction

        static function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
            logic [31:0] c;
            c = acc ^ {24'h0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_MAGIC:       regs.magic       = val;
                CFG_VERSION:     regs.version     = val[15:0];
                CFG_CHECK_GEOM:  regs.check_geom  = val[0];
                CFG_CAPACITY:    regs.capacity    = val;
                CFG_RECORD_SIZE: regs.record_size = val;
                CFG_RESERVED:    regs.reserved    = val;
                default:         ;
            endcase
        endfunction

        function logic [31:0] word_at(int off);
            return {image[off+3], image[off+2], image[off+1], image[off]};
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Advance the record state by one accepted byte; queue a verdict on last.
        function void take_byte(logic [7:0] b, logic last);
            verdict_t    v;
            logic [31:0] cap;
            logic [31:0] rsz;
            logic [31:0] rsv;
            int          taken;
            taken = pos;
            if (taken < REC_LEN)
                image[taken] = b;
            if (taken < CRC_LEN)
                crc_acc = crc_step(crc_acc, b);
            if (taken < POS_SAT)
                pos = taken + 1;
            if (!last)
                return;
            v = '0;
            if (taken + 1 != REC_LEN)
            begin
                v.fail_code = FAIL_LENGTH;
            end
            else
            begin
                cap                 = word_at(8);
                rsz                 = word_at(12);
                rsv                 = word_at(16);
                v.head_index        = word_at(20);
                v.tail_index        = word_at(24);
                v.entry_count       = word_at(28);
                v.generation_number = word_at(32);
                if (word_at(0) != regs.magic)
                    v.fail_code = FAIL_MAGIC;
                else if ({image[5], image[4]} != regs.version)
                    v.fail_code = FAIL_VERSION;
                else if ({image[7], image[6]} != HDR_SIZE)
                    v.fail_code = FAIL_HDR_SIZE;
                else if (word_at(36) != ~crc_acc)
                    v.fail_code = FAIL_CRC;
                else if (cap == 32'd0 || rsz == 32'd0 || rsv == 32'd0)
                    v.fail_code = FAIL_ZERO_SIZE;
                else if (v.entry_count > cap)
                    v.fail_code = FAIL_OVER_CAP;
                else if (v.tail_index < v.head_index)
                    v.fail_code = FAIL_TAIL_HEAD;
                else if (v.entry_count != v.tail_index - v.head_index)
                    v.fail_code = FAIL_COUNT;
                else if (regs.check_geom && (cap != regs.capacity ||
                         rsz != regs.record_size || rsv != regs.reserved))
                    v.fail_code = FAIL_GEOMETRY;
                else
                    v.fail_code = FAIL_OK;
            end
            v.valid_res = (v.fail_code == FAIL_OK);
            pos         = 0;
            crc_acc     = CRC_INIT;
            expected_verdicts = {expected_verdicts, v};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb_top: mismatch on %s: got %h, expected %h (verdict %0d)",
                         what, got, want, verdicts_checked);
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                report("unexpected verdict", 32'(got.fail_code), 32'd0);
                return;
            end
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (got.valid_res != want.valid_res)
                report("valid_res", 32'(got.valid_res), 32'(want.valid_res));
            if (got.fail_code != want.fail_code)
                report("fail_code", 32'(got.fail_code), 32'(want.fail_code));
            if (got.head_index != want.head_index)
                report("head_index", got.head_index, want.head_index);
            if (got.tail_index != want.tail_index)
                report("tail_index", got.tail_index, want.tail_index);
            if (got.entry_count != want.entry_count)
                report("entry_count", got.entry_count, want.entry_count);
            if (got.generation_number != want.generation_number)
                report("generation_number", got.generation_number,
                       want.generation_number);
            if (got == want)
                codes_seen[want.fail_code] = 1'b1;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic                 empty;
    logic                 pop;
    logic                 valid_res;
    logic [FAIL_W-1:0]    fail_code;
    logic [31:0]          head_index;
    logic [31:0]          tail_index;
    logic [31:0]          entry_count;
    logic [31:0]          generation_number;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    record_verdict_board board;
    int cycle_count = 0;
    int hold_asks   = 0;
    int bytes_sent  = 0;
    int full_stalls = 0;
    int burst_left  = 0;
    bit steady      = 1'b0;

    queue_index_record_validator_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: check at the edge, then pick the next pop.
    initial
    begin : verdict_drain
        verdict_t got;
        int       hold_left;
        int       holds_served;
        logic     take;
        hold_left    = 0;
        holds_served = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got = {valid_res, fail_code, head_index, tail_index, entry_count,
                       generation_number};
                board.check_verdict(got);
            end
            if (hold_asks != holds_served)
            begin
                holds_served = hold_asks;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (cycle_count[8:7])
                    2'd0:    take = 1'b1;
                    2'd1:    take = 1'($urandom_range(0, 1));
                    2'd2:    take = (cycle_count[1:0] == 2'd0);
                    default: take = ($urandom_range(0, 4) != 0);
                endcase
            end
            pop <= take;
        end
    end

    function automatic logic [31:0] nonzero32();
        logic [31:0] v;
        v = $urandom;
        return (v == 32'd0) ? 32'd1 : v;
    endfunction

    function automatic logic [31:0] pick_upto(logic [31:0] lim);
        return (lim == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, lim);
    endfunction

    function automatic logic [31:0] pick_size();
        return $urandom_range(0, 1) ? $urandom_range(1, 64) : nonzero32();
    endfunction

    function automatic logic [31:0] spread32();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 64);
            default: return $urandom;
        endcase
    endfunction

    // Built to pass under the current registers; fails if geometry is on with a zero size.
    function automatic idx_rec_t good_record();
        idx_rec_t r;
        r.magic   = board.regs.magic;
        r.version = board.regs.version;
        r.hdr     = HDR_SIZE;
        if (board.regs.check_geom)
        begin
            r.cap = board.regs.capacity;
            r.rsz = board.regs.record_size;
            r.rsv = board.regs.reserved;
        end
        else
        begin
            r.cap = pick_size();
            r.rsz = pick_size();
            r.rsv = pick_size();
        end
        r.cnt  = pick_upto(r.cap);
        r.head = pick_upto(~r.cnt);
        r.tail = r.head + r.cnt;
        r.gen  = $urandom;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if (!steady && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_record(input idx_rec_t r, input logic [31:0] flip, input int len);
        logic [8*CRC_LEN-1:0] body;
        logic [31:0]          crc;
        logic [7:0]           b;
        body = {r.gen, r.cnt, r.tail, r.head, r.rsv, r.rsz, r.cap, r.hdr, r.version,
                r.magic};
        crc  = CRC_INIT;
        for (int i = 0; i < CRC_LEN; i++)
            crc = record_verdict_board::crc_step(crc, body[8*i +: 8]);
        crc = ~crc ^ flip;
        for (int i = 0; i < len; i++)
        begin
            if (i < CRC_LEN)
                b = body[8*i +: 8];
            else if (i < REC_LEN)
                b = crc[8*(i-CRC_LEN) +: 8];
            else
                b = 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    // Start from a record built to pass and break it, aiming for the named check to trip first.
    task automatic send_case(input logic [FAIL_W-1:0] aim);
        idx_rec_t    r;
        logic [31:0] flip;
        int          len;
        r    = good_record();
        flip = '0;
        len  = REC_LEN;
        case (aim)
            FAIL_LENGTH:
                len = $urandom_range(0, 1) ? $urandom_range(1, REC_LEN - 1)
                                           : $urandom_range(REC_LEN + 1, 2 * REC_LEN);
            FAIL_MAGIC:    r.magic   ^= nonzero32();
            FAIL_VERSION:  r.version ^= 16'($urandom_range(1, 16'hFFFF));
            FAIL_HDR_SIZE: r.hdr     ^= 16'($urandom_range(1, 16'hFFFF));
            FAIL_CRC:      flip       = nonzero32();
            FAIL_ZERO_SIZE:
                case ($urandom_range(0, 2))
                    0:       r.cap = '0;
                    1:       r.rsz = '0;
                    default: r.rsv = '0;
                endcase
            FAIL_OVER_CAP:
                if (r.cap != 32'hFFFF_FFFF)
                begin
                    r.cnt  = r.cap + 32'd1 + pick_upto(~r.cap - 32'd1);
                    r.head = pick_upto(~r.cnt);
                    r.tail = r.head + r.cnt;
                end
            FAIL_TAIL_HEAD:
            begin
                r.head = 32'd1 + pick_upto(32'hFFFF_FFFE);
                r.tail = pick_upto(r.head - 32'd1);
            end
            FAIL_COUNT:
                if (r.tail < 32'hFFFF_FFF0)
                    r.tail += $urandom_range(1, 7);
                else
                    r.head -= $urandom_range(1, 7);
            FAIL_GEOMETRY:
                case ($urandom_range(0, 2))
                    0:       r.rsz ^= nonzero32();
                    1:       r.rsv ^= nonzero32();
                    default: r.cap ^= nonzero32();
                endcase
            default: ;
        endcase
        send_record(r, flip, len);
    endtask

    task automatic send_raw(input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                RAW_ZERO: b = 8'h00;
                RAW_ONES: b = 8'hFF;
                default:  b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering bytes and wait out every outstanding verdict.
    task automatic let_verdicts_drain();
        int waited;
        push <= 1'b0;
        burst_left = 0;
        waited     = 0;
        @(posedge clk);
        while (board.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        idx_rec_t         r;
        logic [FAIL_W-1:0] aim;
        int               pick;
        board = new();
        rst_n     <= 1'b0;
        push      <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAGIC;
        cfg_data  <= 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: one record per check but geometry, then a short and a long one.
        for (int c = FAIL_OK; c < FAIL_GEOMETRY; c++)
            send_case(c[FAIL_W-1:0]);
        send_record(good_record(), 32'd0, 1);
        send_record(good_record(), 32'd0, REC_LEN + 1);

        // All-ones registers, geometry on, unknown indexes ignored.
        let_verdicts_drain();
        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_VERSION, 32'hFFFF_FFFF);
        write_reg(CFG_CHECK_GEOM, 32'd1);
        write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
        write_reg(CFG_RECORD_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_RESERVED, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE, 32'd0);
        write_reg(CFG_SPARE_TOP, 32'h1234_5678);
        r      = good_record();
        r.head = '0;
        r.cnt  = '1;
        r.tail = '1;
        send_record(r, 32'd0, REC_LEN);
        r.head = '1;
        r.cnt  = '0;
        r.gen  = '1;
        send_record(r, 32'd0, REC_LEN);
        send_case(FAIL_GEOMETRY);

        // All-zero registers: geometry forces zero sizes, then geometry off with version zero.
        let_verdicts_drain();
        write_reg(CFG_MAGIC, 32'd0);
        write_reg(CFG_VERSION, 32'd0);
        write_reg(CFG_CAPACITY, 32'd0);
        write_reg(CFG_RECORD_SIZE, 32'd0);
        write_reg(CFG_RESERVED, 32'd0);
        send_case(FAIL_OK);
        let_verdicts_drain();
        write_reg(CFG_CHECK_GEOM, 32'd0);
        send_case(FAIL_OK);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            let_verdicts_drain();
            write_reg(CFG_MAGIC, spread32());
            write_reg(CFG_VERSION, $urandom);
            write_reg(CFG_CHECK_GEOM, $urandom);
            write_reg(CFG_CAPACITY, spread32());
            write_reg(CFG_RECORD_SIZE, spread32());
            write_reg(CFG_RESERVED, spread32());
            write_reg(CFG_SPARE, $urandom);
            // Phase 1 backs up the block behind a long receiver hold.
            steady = (p == 1);
            if (p == 1)
                hold_asks++;
            for (int n = 0; n < RECS_PER_PHASE; n++)
            begin
                if (p == 0 && n == RECS_PER_PHASE / 2)
                    let_verdicts_drain();
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    send_case(FAIL_OK);
                end
                else if (pick < 9)
                begin
                    aim = FAIL_W'($urandom_range(FAIL_LENGTH, FAIL_GEOMETRY));
                    send_case(aim);
                end
                else
                begin
                    send_raw($urandom_range(1, REC_LEN + 4), RAW_RANDOM);
                end
            end
        end

        let_verdicts_drain();
        if (board.pending() != 0)
            board.report("verdicts never delivered", board.pending(), 32'd0);
        $display("tb_top: %0d record bytes pushed, %0d verdicts checked, %0d input stalls",
                 bytes_sent, board.verdicts_checked, full_stalls);
        $display("tb_top: check codes matched (bit per code) %011b, %0d mismatches",
                 board.codes_seen[10:0], board.mismatches);
        if (board.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/qirv_pkg.sv
src/qirv_fifo.sv
src/qirv_front.sv
src/qirv_back.sv
src/queue_index_record_validator_unit.sv
src/qirv_checker.sv
tb/tb_top.sv
